@@ design/hler_pkg.sv @@
package hler_pkg;

   localparam int POS_WIDTH    = 32;
   localparam int CNT_WIDTH    = 16;
   localparam int IDX_W        = 5;
   localparam int NUM_AXES     = 2;
   localparam int NUM_SENSORS  = 3;
   localparam int NUM_COUNTS   = 2 * NUM_SENSORS;

   // Entry layout: axis*14 + {0 min, 1 max, 2 + 4*sensor + kind}; 28/29 separation
   localparam logic [IDX_W-1:0] AXIS_ENTRIES  = 5'd14;
   localparam logic [IDX_W-1:0] MIN_OFFSET    = 5'd0;
   localparam logic [IDX_W-1:0] MAX_OFFSET    = 5'd1;
   localparam logic [IDX_W-1:0] ANGLE_OFFSET  = 5'd2;
   localparam logic [IDX_W-1:0] SEP_MIN_INDEX = 5'd28;
   localparam logic [IDX_W-1:0] SEP_MAX_INDEX = 5'd29;

   localparam logic [1:0] KIND_LOWER     = 2'd0;
   localparam logic [1:0] KIND_UPPER     = 2'd1;
   localparam logic [1:0] KIND_LOWER_DEC = 2'd2;
   localparam logic [1:0] KIND_UPPER_DEC = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   typedef logic signed [POS_WIDTH-1:0] pos_type;
   typedef logic [CNT_WIDTH-1:0]        cnt_type;

   // Classified request passed from front to back
   typedef struct packed {
      logic              axis;
      logic              first;
      logic              found;
      logic [IDX_W-1:0]  angle_idx;
      pos_type           angle_val;
      pos_type           rel;
   } hler_rec_type;

   typedef struct packed {
      logic [IDX_W-1:0]  entry_index;
      pos_type           entry_value;
      logic              run_end;
   } hler_rsp_type;

   function automatic pos_type sat_sub(input pos_type a, input pos_type b);
      logic signed [POS_WIDTH:0] d;
      pos_type r;
      d = {a[POS_WIDTH-1], a} - {b[POS_WIDTH-1], b};
      if (d[POS_WIDTH] != d[POS_WIDTH-1]) begin
         r = d[POS_WIDTH] ? POS_MIN : POS_MAX;
      end else begin
         r = d[POS_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/hler_if.sv @@
interface hler_req_if import hler_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    which_axis;
   pos_type sample_position;
   pos_type rise_latch_position;
   pos_type fall_latch_position;
   cnt_type front_rise_count;
   cnt_type front_fall_count;
   cnt_type cal_rise_count;
   cnt_type cal_fall_count;
   cnt_type back_rise_count;
   cnt_type back_fall_count;

   modport source (
      output valid, which_axis, sample_position, rise_latch_position,
             fall_latch_position, front_rise_count, front_fall_count,
             cal_rise_count, cal_fall_count, back_rise_count, back_fall_count,
      input  ready
   );
   modport sink (
      input  valid, which_axis, sample_position, rise_latch_position,
             fall_latch_position, front_rise_count, front_fall_count,
             cal_rise_count, cal_fall_count, back_rise_count, back_fall_count,
      output ready
   );
endinterface

interface hler_rsp_if import hler_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] entry_index;
   pos_type          entry_value;
   logic             run_end;

   modport source (output valid, entry_index, entry_value, run_end, input ready);
   modport sink   (input valid, entry_index, entry_value, run_end, output ready);
endinterface

@@ design/hall_edge_limit_recorder_core.sv @@
// Channel   Dir  Handshake            Payload
// req_bus   in   valid/ready          which_axis, positions, front/cal/back rise and fall edge counters
// rsp_bus   out  valid/ready          entry_index, entry_value, run_end
//
// One request per cycle is taken while the 4-entry request queue has room.
// The back end drains one queued request per cycle while the 4-entry response
// buffer has room for two, writing up to two; the port sends one per ready cycle.
// Sync reset clears control, learned min/max, separation and start flags.
// A stalled rsp_bus fills the buffer, then the queue, then drops req_bus.ready.
module hall_edge_limit_recorder_core import hler_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hler_req_if.sink   req_bus,
   hler_rsp_if.source rsp_bus
);

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;
   hler_rec_type q_in_rec;
   hler_rec_type q_head_rec;

   hler_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_rec   (q_in_rec)
   );

   hler_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_in_rec),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_rec (q_head_rec)
   );

   hler_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_rec   (q_head_rec),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.entry_index <= SEP_MAX_INDEX))
      else $error("entry index out of range");

   a_sep_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.entry_index == SEP_MIN_INDEX ||
                        rsp_bus.entry_index == SEP_MAX_INDEX) |-> rsp_bus.run_end)
      else $error("separation response not marked last");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("request queue overflow");

endmodule

@@ design/hler_front.sv @@
module hler_front import hler_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   hler_req_if.sink     req_bus,
   input  logic         q_full,
   output logic         q_push,
   output hler_rec_type q_rec
);

   logic    started_ff [NUM_AXES];
   pos_type origin_ff  [NUM_AXES];
   pos_type prev_pos_ff[NUM_AXES];
   cnt_type prev_cnt_ff[NUM_AXES][NUM_COUNTS];

   cnt_type cur_cnt[NUM_COUNTS];
   logic    axis;
   logic    accept;
   logic    found;
   logic    use_fall;
   logic [1:0] sensor;
   logic [1:0] kind;
   logic    rise_below;
   logic    fall_above;
   pos_type latch;
   logic [IDX_W-1:0] base;

   assign axis = req_bus.which_axis;
   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;

   assign cur_cnt[0] = req_bus.front_rise_count;
   assign cur_cnt[1] = req_bus.front_fall_count;
   assign cur_cnt[2] = req_bus.cal_rise_count;
   assign cur_cnt[3] = req_bus.cal_fall_count;
   assign cur_cnt[4] = req_bus.back_rise_count;
   assign cur_cnt[5] = req_bus.back_fall_count;

   assign rise_below = req_bus.rise_latch_position < prev_pos_ff[axis];
   assign fall_above = req_bus.fall_latch_position > prev_pos_ff[axis];

   // First changed counter wins: front, cal, back; rise before fall
   always_comb begin
      found    = 1'b0;
      use_fall = 1'b0;
      sensor   = 2'd0;
      kind     = KIND_LOWER;
      for (int s = 0; s < NUM_SENSORS; s++) begin
         if (!found) begin
            if (cur_cnt[2*s] != prev_cnt_ff[axis][2*s]) begin
               found    = 1'b1;
               sensor   = 2'(s);
               kind     = rise_below ? KIND_UPPER : KIND_LOWER_DEC;
            end else if (cur_cnt[2*s+1] != prev_cnt_ff[axis][2*s+1]) begin
               found    = 1'b1;
               use_fall = 1'b1;
               sensor   = 2'(s);
               kind     = fall_above ? KIND_UPPER_DEC : KIND_LOWER;
            end
         end
      end
   end

   assign latch = use_fall ? req_bus.fall_latch_position : req_bus.rise_latch_position;
   assign base  = axis ? AXIS_ENTRIES : '0;

   assign q_push          = accept;
   assign q_rec.axis      = axis;
   assign q_rec.first     = !started_ff[axis];
   assign q_rec.found     = found;
   assign q_rec.angle_idx = base + ANGLE_OFFSET + IDX_W'({sensor, kind});
   assign q_rec.angle_val = sat_sub(latch, origin_ff[axis]);
   assign q_rec.rel       = sat_sub(req_bus.sample_position, origin_ff[axis]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            started_ff[a] <= 1'b0;
         end
      end else if (accept) begin
         started_ff[axis] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!started_ff[axis]) begin
            origin_ff[axis] <= req_bus.sample_position;
         end
         prev_pos_ff[axis] <= req_bus.sample_position;
         for (int c = 0; c < NUM_COUNTS; c++) begin
            prev_cnt_ff[axis][c] <= cur_cnt[c];
         end
      end
   end

endmodule

@@ design/hler_queue.sv @@
module hler_queue import hler_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hler_rec_type push_rec,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output hler_rec_type head_rec
);

   hler_rec_type     mem_ff[QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_rec = mem_ff[rptr_ff];
   assign do_pop   = pop && !empty;

   assign wptr_in = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
   assign rptr_in = do_pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
   assign cnt_in  = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

@@ design/hler_back.sv @@
module hler_back import hler_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  hler_rec_type q_rec,
   output logic         q_pop,
   hler_rsp_if.source   rsp_bus
);

   pos_type min_ff[NUM_AXES];
   pos_type max_ff[NUM_AXES];
   pos_type sep_min_ff;
   pos_type sep_max_ff;
   pos_type top_rel_ff;

   hler_rsp_type     buf_ff[OUT_DEPTH];
   logic [OPTR_W-1:0] wptr_ff, wptr_in;
   logic [OPTR_W-1:0] rptr_ff, rptr_in;
   logic [OCNT_W-1:0] cnt_ff, cnt_in;
   logic [OCNT_W-1:0] occ;

   logic             deq;
   logic             work;
   logic             a_v, b_v;
   logic             above_max, below_min;
   logic             sep_above, sep_below;
   logic [IDX_W-1:0] base;
   pos_type          sep;
   hler_rsp_type     res_a, res_b;
   logic [OPTR_W-1:0] w_next;

   assign deq   = rsp_bus.valid && rsp_bus.ready;
   assign occ   = cnt_ff - OCNT_W'(deq);
   // take a request only when both of its possible responses fit
   assign q_pop = !q_empty && (occ <= OCNT_W'(OUT_DEPTH - 2));
   assign work  = q_pop && !q_rec.first;

   assign base      = q_rec.axis ? AXIS_ENTRIES : '0;
   assign above_max = q_rec.rel > max_ff[q_rec.axis];
   assign below_min = q_rec.rel < min_ff[q_rec.axis];
   assign sep       = sat_sub(top_rel_ff, q_rec.rel);
   assign sep_above = sep > sep_max_ff;
   assign sep_below = sep < sep_min_ff;

   assign a_v = work && (q_rec.found || above_max || below_min);
   assign b_v = work && q_rec.axis && (sep_above || sep_below);

   always_comb begin
      res_a.run_end = !b_v;
      if (q_rec.found) begin
         res_a.entry_index = q_rec.angle_idx;
         res_a.entry_value = q_rec.angle_val;
      end else begin
         res_a.entry_index = base + (above_max ? MAX_OFFSET : MIN_OFFSET);
         res_a.entry_value = q_rec.rel;
      end
      res_b.entry_index = sep_above ? SEP_MAX_INDEX : SEP_MIN_INDEX;
      res_b.entry_value = sep;
      res_b.run_end     = 1'b1;
   end

   assign w_next  = a_v ? wptr_ff + OPTR_W'(1) : wptr_ff;
   assign wptr_in = wptr_ff + OPTR_W'(a_v) + OPTR_W'(b_v);
   assign rptr_in = deq ? rptr_ff + OPTR_W'(1) : rptr_ff;
   assign cnt_in  = occ + OCNT_W'(a_v) + OCNT_W'(b_v);

   assign rsp_bus.valid       = (cnt_ff != '0);
   assign rsp_bus.entry_index = buf_ff[rptr_ff].entry_index;
   assign rsp_bus.entry_value = buf_ff[rptr_ff].entry_value;
   assign rsp_bus.run_end     = buf_ff[rptr_ff].run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_v) begin
         buf_ff[wptr_ff] <= res_a;
      end
      if (b_v) begin
         buf_ff[w_next] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
         sep_min_ff <= '0;
         sep_max_ff <= '0;
         top_rel_ff <= '0;
      end else if (q_pop) begin
         if (q_rec.first) begin
            if (!q_rec.axis) begin
               top_rel_ff <= '0;
            end
         end else begin
            if (!q_rec.found) begin
               if (above_max) begin
                  max_ff[q_rec.axis] <= q_rec.rel;
               end else if (below_min) begin
                  min_ff[q_rec.axis] <= q_rec.rel;
               end
            end
            if (!q_rec.axis) begin
               top_rel_ff <= q_rec.rel;
            end else if (sep_above) begin
               sep_max_ff <= sep;
            end else if (sep_below) begin
               sep_min_ff <= sep;
            end
         end
      end
   end

endmodule
